// File: rtl/srfr_pkg.sv
// shared types and constants of the scanner reply frame receiver
`timescale 1ns / 1ps
`default_nettype none

package srfr_pkg;

    typedef enum logic [1:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_CMD,
        PH_BODY
    } t_phase;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 12;
    localparam int CODE_W  = 4;
    localparam int FLAG_W  = 5;

    localparam logic [CODE_W-1:0] RC_OK       = 4'd0;
    localparam logic [CODE_W-1:0] RC_CHECKSUM = 4'd1;
    localparam logic [CODE_W-1:0] RC_NOT_ACK  = 4'd2;
    localparam logic [CODE_W-1:0] RC_DEV_ERR  = 4'd3;
    localparam logic [CODE_W-1:0] RC_WARNING  = 4'd4;
    localparam logic [CODE_W-1:0] RC_STATUS   = 4'd5;
    localparam logic [CODE_W-1:0] RC_MALFUNC  = 4'd6;
    localparam logic [CODE_W-1:0] RC_INHIBIT  = 4'd7;
    localparam logic [CODE_W-1:0] RC_OVERFLOW = 4'd8;

    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_INVALID = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_NOT_ACK = 8'h17;
    localparam logic [BYTE_W-1:0] CMD_DEV_ERR = 8'h53;
    localparam logic [BYTE_W-1:0] CMD_WARNING = 8'h54;
    localparam logic [BYTE_W-1:0] SUM_ZERO_MAP = 8'hFF;

    localparam logic [COUNT_W-1:0] LIMIT_RESET     = 12'd1098;
    localparam logic [COUNT_W-1:0] CMD_COUNT       = 12'd3;
    localparam logic [COUNT_W-1:0] BYTE3_COUNT     = 12'd4;
    localparam logic [COUNT_W-1:0] BYTE4_COUNT     = 12'd5;
    localparam logic [COUNT_W-1:0] BYTE5_COUNT     = 12'd6;
    localparam logic [COUNT_W-1:0] MIN_FRAME_LEN   = 12'd6;

    localparam int ZF_NEAR_ONE = 0;
    localparam int ZF_FAR_ONE  = 1;
    localparam int ZF_NEAR_TWO = 2;
    localparam int ZF_FAR_TWO  = 3;
    localparam int ZF_PAIR     = 4;

    typedef struct packed {
        logic [BYTE_W-1:0]   check;
        logic [BYTE_W-1:0]   sum;
        logic [4*BYTE_W-1:0] header;
        logic [FLAG_W-1:0]   flags;
    } t_dec_req;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [BYTE_W-1:0]  command;
        logic [COUNT_W-1:0] length;
        logic [FLAG_W-1:0]  flags;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/scanner_reply_frame_receiver_top.sv
// Scanner reply frame receiver: takes one received byte per cycle, hunts for the
// two zero sync bytes and a valid command byte, collects the frame up to three
// trailing zeros and reports one result per frame (or per overflow). The
// result appears in the output register on the cycle after
// the closing byte is accepted. The input is held off only while a result sits
// in the output register and the downstream side is not ready. The byte limit
// register takes effect at once, also in mid-frame.
`timescale 1ns / 1ps
`default_nettype none

module scanner_reply_frame_receiver_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [11:0] i_cfg_wr_data,    // frame_byte_limit
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // rx_byte
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // result_code[3:0], reply_command[11:4], frame_length[23:12], near_one[24],
    // far_one[25], near_two[26], far_two[27], field_pair_flag[28], zero[31:29]
    output logic [31:0] o_m_axis_tdata
);

    logic [srfr_pkg::COUNT_W-1:0] r_limit;
    logic                         r_m_valid;
    srfr_pkg::t_result            r_m_res;
    logic                         accept;
    logic                         res_valid;
    srfr_pkg::t_result            res;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= srfr_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    srfr_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_axis_tdata),
        .i_limit     (r_limit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept && res_valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {3'b000,
                              r_m_res.flags[srfr_pkg::ZF_PAIR],
                              r_m_res.flags[srfr_pkg::ZF_FAR_TWO],
                              r_m_res.flags[srfr_pkg::ZF_NEAR_TWO],
                              r_m_res.flags[srfr_pkg::ZF_FAR_ONE],
                              r_m_res.flags[srfr_pkg::ZF_NEAR_ONE],
                              r_m_res.length,
                              r_m_res.command,
                              r_m_res.code};

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_m_valid && !i_m_axis_tready))
        else $error("input held off without a pending result");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_valid) |=> o_m_axis_tvalid)
        else $error("result request lost");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_res.code <= srfr_pkg::RC_OVERFLOW))
        else $error("result code out of range");

    a_min_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_res.code != srfr_pkg::RC_OVERFLOW))
            |-> (r_m_res.length >= srfr_pkg::MIN_FRAME_LEN))
        else $error("closed frame shorter than the minimum");

endmodule

`default_nettype wire

// File: rtl/srfr_decode.sv
// reply code and zone flag decoding at the end of a frame
`timescale 1ns / 1ps
`default_nettype none

module srfr_decode (
    input  wire srfr_pkg::t_dec_req           i_req,
    output logic [srfr_pkg::CODE_W-1:0]       o_code,
    output logic [srfr_pkg::FLAG_W-1:0]       o_flags
);

    logic [srfr_pkg::BYTE_W-1:0] sum_mapped;
    logic [srfr_pkg::BYTE_W-1:0] cmd;
    logic [srfr_pkg::BYTE_W-1:0] b3;
    logic [srfr_pkg::BYTE_W-1:0] b4;
    logic [srfr_pkg::BYTE_W-1:0] b5;

    assign cmd = i_req.header[7:0];
    assign b3  = i_req.header[15:8];
    assign b4  = i_req.header[23:16];
    assign b5  = i_req.header[31:24];

    always_comb begin
        sum_mapped = (i_req.sum == '0) ? srfr_pkg::SUM_ZERO_MAP : i_req.sum;
        o_flags    = i_req.flags;
        o_code     = srfr_pkg::RC_OK;
        if (sum_mapped != i_req.check) begin
            o_code = srfr_pkg::RC_CHECKSUM;
        end else if (cmd == srfr_pkg::CMD_NOT_ACK) begin
            o_code = srfr_pkg::RC_NOT_ACK;
        end else if (cmd == srfr_pkg::CMD_DEV_ERR) begin
            o_code = srfr_pkg::RC_DEV_ERR;
        end else if (cmd == srfr_pkg::CMD_WARNING) begin
            o_code = srfr_pkg::RC_WARNING;
        end else if (b3[4]) begin
            o_code = srfr_pkg::RC_STATUS;
        end else if (b3[1]) begin
            o_flags[srfr_pkg::ZF_NEAR_ONE] = b4[0];
            o_flags[srfr_pkg::ZF_FAR_ONE]  = b4[1];
            if (b4[3]) begin
                o_code = srfr_pkg::RC_MALFUNC;
            end else if (b4[4]) begin
                o_code = srfr_pkg::RC_INHIBIT;
            end else begin
                o_flags[srfr_pkg::ZF_NEAR_TWO] = b4[5];
                o_flags[srfr_pkg::ZF_FAR_TWO]  = b4[6];
                if (b4[7]) begin
                    o_flags[srfr_pkg::ZF_PAIR] = b5[6];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/srfr_frame.sv
// sync hunt, frame collection and overflow check, one byte per cycle while i_accept is high
`timescale 1ns / 1ps
`default_nettype none

module srfr_frame (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_accept,
    input  wire  [srfr_pkg::BYTE_W-1:0]        i_byte,
    input  wire  [srfr_pkg::COUNT_W-1:0]       i_limit,
    output logic                               o_res_valid,
    output srfr_pkg::t_result                  o_res
);

    srfr_pkg::t_phase r_phase, n_phase;
    logic [srfr_pkg::BYTE_W-1:0]   r_xor, n_xor;
    logic [srfr_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [4*srfr_pkg::BYTE_W-1:0] r_recent, n_recent;
    logic [4*srfr_pkg::BYTE_W-1:0] r_header, n_header;
    logic [srfr_pkg::FLAG_W-1:0]   r_flags, n_flags;

    logic [srfr_pkg::COUNT_W-1:0]  body_count;
    logic [4*srfr_pkg::BYTE_W-1:0] body_recent;
    logic [4*srfr_pkg::BYTE_W-1:0] body_header;
    logic [srfr_pkg::BYTE_W-1:0]   body_xor;
    logic                          overflow;
    logic                          term;
    logic                          cmd_bad;

    srfr_pkg::t_dec_req            dec_req;
    logic [srfr_pkg::CODE_W-1:0]   dec_code;
    logic [srfr_pkg::FLAG_W-1:0]   dec_flags;

    assign body_count  = r_count + srfr_pkg::COUNT_W'(1);
    assign body_xor    = r_xor ^ i_byte;
    assign body_recent = {r_recent[3*srfr_pkg::BYTE_W-1:0], i_byte};
    assign overflow    = (r_count >= i_limit);
    assign term        = (body_recent[3*srfr_pkg::BYTE_W-1:0] == '0);
    assign cmd_bad     = (i_byte == srfr_pkg::SYNC_BYTE) || (i_byte == srfr_pkg::CMD_INVALID);

    always_comb begin
        body_header = r_header;
        if (body_count == srfr_pkg::BYTE3_COUNT) begin
            body_header[15:8] = i_byte;
        end else if (body_count == srfr_pkg::BYTE4_COUNT) begin
            body_header[23:16] = i_byte;
        end else if (body_count == srfr_pkg::BYTE5_COUNT) begin
            body_header[31:24] = i_byte;
        end
    end

    assign dec_req.check  = body_recent[4*srfr_pkg::BYTE_W-1:3*srfr_pkg::BYTE_W];
    assign dec_req.sum    = body_xor ^ body_recent[4*srfr_pkg::BYTE_W-1:3*srfr_pkg::BYTE_W];
    assign dec_req.header = body_header;
    assign dec_req.flags  = r_flags;

    srfr_decode u_decode (
        .i_req   (dec_req),
        .o_code  (dec_code),
        .o_flags (dec_flags)
    );

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                srfr_pkg::PH_SYNC0: begin
                    if (i_byte == srfr_pkg::SYNC_BYTE) begin
                        n_phase = srfr_pkg::PH_SYNC1;
                    end
                end
                srfr_pkg::PH_SYNC1: begin
                    n_phase = (i_byte == srfr_pkg::SYNC_BYTE) ? srfr_pkg::PH_CMD
                                                              : srfr_pkg::PH_SYNC0;
                end
                srfr_pkg::PH_CMD: begin
                    n_phase = cmd_bad ? srfr_pkg::PH_SYNC0 : srfr_pkg::PH_BODY;
                end
                srfr_pkg::PH_BODY: begin
                    if (overflow || term) begin
                        n_phase = srfr_pkg::PH_SYNC0;
                    end
                end
                default: n_phase = srfr_pkg::PH_SYNC0;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_xor       = r_xor;
        n_count     = r_count;
        n_recent    = r_recent;
        n_header    = r_header;
        n_flags     = r_flags;
        o_res_valid = 1'b0;
        o_res.code    = srfr_pkg::RC_OVERFLOW;
        o_res.command = r_header[7:0];
        o_res.length  = body_count;
        o_res.flags   = r_flags;
        if (i_accept) begin
            unique case (r_phase)
                srfr_pkg::PH_CMD: begin
                    if (!cmd_bad) begin
                        n_xor    = i_byte;
                        n_recent = {{(3*srfr_pkg::BYTE_W){1'b0}}, i_byte};
                        n_header = {{(3*srfr_pkg::BYTE_W){1'b0}}, i_byte};
                        n_count  = srfr_pkg::CMD_COUNT;
                    end
                end
                srfr_pkg::PH_BODY: begin
                    if (overflow) begin
                        o_res_valid = 1'b1;
                    end else begin
                        n_xor    = body_xor;
                        n_count  = body_count;
                        n_recent = body_recent;
                        n_header = body_header;
                        if (term) begin
                            n_flags       = dec_flags;
                            o_res_valid   = 1'b1;
                            o_res.code    = dec_code;
                            o_res.command = body_header[7:0];
                            o_res.flags   = dec_flags;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= srfr_pkg::PH_SYNC0;
            r_xor    <= '0;
            r_count  <= '0;
            r_recent <= '0;
            r_header <= '0;
            r_flags  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_xor    <= n_xor;
            r_count  <= n_count;
            r_recent <= n_recent;
            r_header <= n_header;
            r_flags  <= n_flags;
        end
    end

endmodule

`default_nettype wire
